/* hw/rtl/lds_pkg.sv */
package lds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int ROW_W      = 16;
  localparam int CH_W       = 8;
  localparam int OUT_W      = 11;
  localparam int FACT_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [WID_W-1:0]  WIDTH_RESET  = WID_W'(1024);
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(1024);
  localparam logic [FACT_W-1:0] FACTOR_RESET = FACT_W'(64);
  localparam logic [FACT_W-1:0] FACTOR_ONE   = FACT_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FACTOR = 2'd2
  } cfg_idx_t;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] red;
    logic signed [OUT_W-1:0] green;
    logic signed [OUT_W-1:0] blue;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    last;
  } res_t;

  typedef struct packed {
    pix_t              cur;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [FACT_W-1:0] factor;
    logic              has_prev;
    logic              last_row;
    logic              last_col;
    logic              interior;
  } stage_t;

endpackage

/* hw/rtl/lds_diffuse.sv */
module lds_diffuse (
  input  logic [lds_pkg::CH_W-1:0]          ctr,
  input  logic [lds_pkg::CH_W-1:0]          left,
  input  logic [lds_pkg::CH_W-1:0]          right,
  input  logic [lds_pkg::CH_W-1:0]          up,
  input  logic [lds_pkg::CH_W-1:0]          down,
  input  logic [lds_pkg::FACT_W-1:0]        factor,
  output logic signed [lds_pkg::OUT_W-1:0]  result
);
  import lds_pkg::*;

  logic [CH_W+1:0]        sum4;
  logic signed [CH_W+3:0] lap;
  logic signed [FACT_W:0] fac_s;
  logic signed [CH_W+FACT_W+4:0] prod;
  logic signed [CH_W+FACT_W-4:0] quo;
  logic signed [CH_W+FACT_W-4:0] val;

  always_comb begin
    sum4  = {2'b00, left} + {2'b00, right} + {2'b00, up} + {2'b00, down};
    lap   = $signed({2'b00, sum4}) - $signed({2'b00, ctr, 2'b00});
    fac_s = $signed({1'b0, factor});
    prod  = fac_s * lap;
    // arithmetic shift: floor division by 256
    quo   = prod[CH_W+FACT_W+4:CH_W];
    val   = quo + $signed({{(FACT_W-3){1'b0}}, ctr});
    if (val > $signed((CH_W+FACT_W-3)'(255))) begin
      result = OUT_W'(255);
    end else begin
      result = val[OUT_W-1:0];
    end
  end

endmodule

/* hw/rtl/lds_res_fifo.sv */
module lds_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_a_valid,
  input  lds_pkg::res_t push_a,
  input  logic          push_b_valid,
  input  lds_pkg::res_t push_b,
  output logic          space_ok,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lds_pkg::res_t pop_data
);
  import lds_pkg::*;

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] n_push;
  res_t                  first;

  always_comb begin
    pop        = pop_valid && pop_ready;
    n_push     = FIFO_CNT_W'(push_a_valid) + FIFO_CNT_W'(push_b_valid);
    first      = push_a_valid ? push_a : push_b;
    space_ok   = (cnt_r - FIFO_CNT_W'(pop)) <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - FIFO_CNT_W'(pop);
    pop_valid  = cnt_r != '0;
    pop_data   = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a_valid || push_b_valid) begin
      mem[wr_ptr_r] <= first;
    end
    if (push_a_valid && push_b_valid) begin
      mem[wr_ptr_r + FIFO_PTR_W'(1)] <= push_b;
    end
  end

endmodule

/* hw/rtl/laplacian_diffusion_stencil_top.sv */
// Five-point Laplacian diffusion over an RGB frame streamed in raster order.
// One pixel is taken per cycle while the result FIFO has room; results are
// queued there. When pixel (r,c) is taken, result (r-1,c) is produced; on
// the last row the pixel (r,c) is also produced as an unchanged copy, so
// there each pixel yields two results and, with the single result port
// draining one per cycle, input is throttled to match. The rows above are
// held in two 1024 x 24 synchronous line memories; the middle one is read at
// columns c and c+1 in the same cycle. Border pixels pass through. Interior
// results are c + ((f*lap) >>> 8), clamped above at 255 and signed below.
// Program the registers only while no pixel is in flight.
module laplacian_diffusion_stencil_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lds_pkg::CH_W-1:0]           in_red,
  input  logic [lds_pkg::CH_W-1:0]           in_green,
  input  logic [lds_pkg::CH_W-1:0]           in_blue,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lds_pkg::OUT_W-1:0]   out_red,
  output logic signed [lds_pkg::OUT_W-1:0]   out_green,
  output logic signed [lds_pkg::OUT_W-1:0]   out_blue,
  output logic [lds_pkg::ROW_W-1:0]          out_row,
  output logic [lds_pkg::COL_W-1:0]          out_col,
  output logic                               out_frame_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lds_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lds_pkg::*;

  logic [WID_W-1:0]  width_r;
  logic [ROW_W-1:0]  height_r;
  logic [FACT_W-1:0] factor_r;

  logic [WID_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [FACT_W-1:0] f_eff;

  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0]  col_p1;

  stage_t            s0;
  stage_t            s1_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_adv;
  logic              in_fire;
  logic              space_ok;

  pix_t              mid_mem [MAX_WIDTH];
  pix_t              up_mem  [MAX_WIDTH];
  pix_t              mid_rd0_r, mid_rd1_r, up_rd_r;

  logic              fwd_valid_r;
  logic [COL_W-1:0]  fwd_col_r;
  pix_t              fwd_cur_r;
  pix_t              fwd_ctr_r;
  pix_t              left_hold_r;

  logic              hit_c, hit_rt;
  logic [COL_W-1:0]  s1_col_p1;
  pix_t              ctr, up, right;
  logic signed [2:0][OUT_W-1:0] dif;
  res_t              res_a, res_b;
  res_t              pop_data;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      factor_r <= FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        CFG_FACTOR: factor_r <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
    f_eff = (factor_r > FACTOR_ONE) ? FACTOR_ONE : factor_r;
  end

  // intake stage
  assign s1_adv   = s1_valid_r && space_ok;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign col_p1   = col_cnt_r + COL_W'(1);

  always_comb begin
    s0.cur      = {in_blue, in_green, in_red};
    s0.row      = row_cnt_r;
    s0.col      = col_cnt_r;
    s0.factor   = f_eff;
    s0.has_prev = row_cnt_r != '0;
    s0.last_row = ({1'b0, row_cnt_r} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
    s0.last_col = ({1'b0, col_cnt_r} + WID_W'(1)) >= w_eff;
    s0.interior = (row_cnt_r >= ROW_W'(2)) && (row_cnt_r <= h_eff - ROW_W'(1)) &&
                  (col_cnt_r != '0) &&
                  (({2'b00, col_cnt_r} + (WID_W+1)'(2)) <= {1'b0, w_eff});

    if (s0.last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = s0.last_row ? '0 : row_cnt_r + ROW_W'(1);
    end else begin
      col_cnt_nxt = col_p1;
      row_cnt_nxt = row_cnt_r;
    end

    s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      left_hold_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        row_cnt_r   <= row_cnt_nxt;
        col_cnt_r   <= col_cnt_nxt;
        fwd_valid_r <= s1_adv;
      end
      if (s1_adv) begin
        left_hold_r <= ctr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r      <= s0;
      fwd_col_r <= s1_r.col;
      fwd_cur_r <= s1_r.cur;
      fwd_ctr_r <= ctr;
    end
  end

  // line memories: read at intake, write back when the stage retires
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mid_mem[s1_r.col] <= s1_r.cur;
    end
    if (in_fire) begin
      mid_rd0_r <= mid_mem[col_cnt_r];
      mid_rd1_r <= mid_mem[col_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      up_mem[s1_r.col] <= ctr;
    end
    if (in_fire) begin
      up_rd_r <= up_mem[col_cnt_r];
    end
  end

  // compute stage, with bypass of the write that overlapped the read
  always_comb begin
    s1_col_p1 = s1_r.col + COL_W'(1);
    hit_c     = fwd_valid_r && (fwd_col_r == s1_r.col);
    hit_rt    = fwd_valid_r && (fwd_col_r == s1_col_p1);
    ctr       = hit_c  ? fwd_cur_r : mid_rd0_r;
    up        = hit_c  ? fwd_ctr_r : up_rd_r;
    right     = hit_rt ? fwd_cur_r : mid_rd1_r;
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    lds_diffuse u_diffuse (
      .ctr    (ctr[k]),
      .left   (left_hold_r[k]),
      .right  (right[k]),
      .up     (up[k]),
      .down   (s1_r.cur[k]),
      .factor (s1_r.factor),
      .result (dif[k])
    );
  end

  always_comb begin
    res_a.red   = s1_r.interior ? dif[0] : $signed({3'b000, ctr[0]});
    res_a.green = s1_r.interior ? dif[1] : $signed({3'b000, ctr[1]});
    res_a.blue  = s1_r.interior ? dif[2] : $signed({3'b000, ctr[2]});
    res_a.row   = s1_r.row - ROW_W'(1);
    res_a.col   = s1_r.col;
    res_a.last  = 1'b0;

    res_b.red   = $signed({3'b000, s1_r.cur[0]});
    res_b.green = $signed({3'b000, s1_r.cur[1]});
    res_b.blue  = $signed({3'b000, s1_r.cur[2]});
    res_b.row   = s1_r.row;
    res_b.col   = s1_r.col;
    res_b.last  = s1_r.last_col;
  end

  lds_res_fifo u_res_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_a_valid (s1_adv && s1_r.has_prev),
    .push_a       (res_a),
    .push_b_valid (s1_adv && s1_r.last_row),
    .push_b       (res_b),
    .space_ok     (space_ok),
    .pop_valid    (out_valid),
    .pop_ready    (out_ready),
    .pop_data     (pop_data)
  );

  assign out_red        = pop_data.red;
  assign out_green      = pop_data.green;
  assign out_blue       = pop_data.blue;
  assign out_row        = pop_data.row;
  assign out_col        = pop_data.col;
  assign out_frame_last = pop_data.last;

`ifndef SYNTHESIS
  a_fire_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted pixel did not reach compute stage");

  a_no_bypass_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !s1_valid_r |=> !fwd_valid_r)
    else $error("bypass armed with no retiring pixel");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_r.col) && $stable(s1_r.row))
    else $error("stalled compute stage lost its pixel");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !s0.last_col |=> col_cnt_r == $past(col_cnt_r) + COL_W'(1))
    else $error("column counter skipped");
`endif

endmodule
